@@ hdl/modbus_response_checker_core_assert.svh @@
// assertion macros for the modbus response checker
// depends on nothing; included by the checker module
`ifndef MODBUS_RESPONSE_CHECKER_CORE_ASSERT_SVH
`define MODBUS_RESPONSE_CHECKER_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define MRC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("modbus checker assertion failed");

// next-cycle implication, disabled during reset
`define MRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("modbus checker assertion failed");

`endif

@@ hdl/mrc_pkg.sv @@
// shared types, constants and crc function of the modbus response checker
// no dependencies
package mrc_pkg;

  localparam int COUNT_WIDTH_DEFAULT = 16;
  localparam int OUT_COUNT_W = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [7:0]  ADDR_RESET = 8'h01;
  localparam logic [7:0]  FUNC_RESET = 8'h03;
  localparam logic [7:0]  BYTE_COUNT = 8'h02;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;

  typedef logic [2:0] pos_t;
  localparam pos_t POS_ADDR  = 3'd0;
  localparam pos_t POS_FUNC  = 3'd1;
  localparam pos_t POS_COUNT = 3'd2;
  localparam pos_t POS_DHIGH = 3'd3;
  localparam pos_t POS_DLOW  = 3'd4;
  localparam pos_t POS_CRCLO = 3'd5;
  localparam pos_t POS_CRCHI = 3'd6;
  localparam pos_t POS_IDLE  = 3'd7;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_HDR   = 2'd1,
    ST_BAD_COUNT = 2'd2,
    ST_CRC_ERR   = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EXP_ADDR = 2'd0,
    REG_EXP_FUNC = 2'd1
  } cfg_reg_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

@@ hdl/mrc_in_if.sv @@
// input channel of the modbus response checker: one received byte per item
// no dependencies
interface mrc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_start;

  modport source (output valid, output rx_byte, output frame_start, input ready);
  modport sink (input valid, input rx_byte, input frame_start, output ready);
endinterface

@@ hdl/mrc_out_if.sv @@
// result channel of the modbus response checker: one checked frame per item
// depends on mrc_pkg
interface mrc_out_if;
  import mrc_pkg::*;
  logic                   valid;
  logic                   ready;
  status_t                status;
  logic [15:0]            distance_mm;
  logic [15:0]            computed_crc;
  logic [15:0]            received_crc;
  logic                   high_byte_changed;
  logic [OUT_COUNT_W-1:0] good_frames;
  logic [OUT_COUNT_W-1:0] crc_failures;
  logic [OUT_COUNT_W-1:0] high_changes;

  modport source (output valid, output status, output distance_mm, output computed_crc,
                  output received_crc, output high_byte_changed, output good_frames,
                  output crc_failures, output high_changes, input ready);
  modport sink (input valid, input status, input distance_mm, input computed_crc,
                input received_crc, input high_byte_changed, input good_frames,
                input crc_failures, input high_changes, output ready);
endinterface

@@ hdl/mrc_cfg_if.sv @@
// register write channel of the modbus response checker
// depends on mrc_pkg
interface mrc_cfg_if;
  import mrc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_index;
  logic [7:0]           wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

@@ hdl/modbus_response_checker_core.sv @@
// Checks 7-byte modbus rtu read replies one byte per item: header, byte count
// and crc-16 over bytes 0 to 4, with saturating frame, crc error and change counts.
// A byte is taken every cycle while in_ready is high; the result item appears in the cycle
// after byte 6 is taken, from a single result register. in_ready drops only while a result waits
// and the next byte would complete a frame. Register writes are taken every cycle.
// Depends on mrc_pkg, mrc_in_if, mrc_out_if and mrc_cfg_if.
module modbus_response_checker_core #(
  parameter int COUNT_WIDTH = mrc_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic  clk,
  input  logic  rst_n,
  mrc_in_if.sink    in_ch,
  mrc_out_if.source out_ch,
  mrc_cfg_if.sink   cfg_ch
);
  import mrc_pkg::*;

  localparam int EXT_W = (COUNT_WIDTH > OUT_COUNT_W) ? COUNT_WIDTH : OUT_COUNT_W;

  logic [7:0]  exp_addr_r, exp_func_r;
  pos_t        pos_r, pos_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic        hdr_ok_r, hdr_ok_nxt;
  logic        cnt_ok_r, cnt_ok_nxt;
  logic [7:0]  dist_hi_r, dist_hi_nxt;
  logic [7:0]  dist_lo_r, dist_lo_nxt;
  logic [7:0]  crc_lo_r, crc_lo_nxt;
  logic [7:0]  prev_hi_r, prev_hi_nxt;
  logic        has_prev_r, has_prev_nxt;
  logic [COUNT_WIDTH-1:0] good_cnt_r, good_cnt_nxt;
  logic [COUNT_WIDTH-1:0] err_cnt_r, err_cnt_nxt;
  logic [COUNT_WIDTH-1:0] chg_cnt_r, chg_cnt_nxt;

  logic        out_valid_r, out_valid_nxt;
  status_t     status_r, status_nxt;
  logic [15:0] dist_out_r, dist_out_nxt;
  logic [15:0] ccrc_out_r, ccrc_out_nxt;
  logic [15:0] rcrc_out_r, rcrc_out_nxt;
  logic        changed_r, changed_nxt;
  logic [OUT_COUNT_W-1:0] good_out_r, good_out_nxt;
  logic [OUT_COUNT_W-1:0] err_out_r, err_out_nxt;
  logic [OUT_COUNT_W-1:0] chg_out_r, chg_out_nxt;

  logic        in_fire, out_hold;
  pos_t        pos_eff;
  logic [15:0] crc_upd, rx_crc;
  logic [EXT_W-1:0] good_ext, err_ext, chg_ext;

  assign out_hold     = out_valid_r && !out_ch.ready;
  assign in_ch.ready  = !out_hold || (pos_r != POS_CRCHI);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign pos_eff = in_ch.frame_start ? POS_ADDR : pos_r;
  assign crc_upd = crc_byte((pos_eff == POS_ADDR) ? CRC_INIT : crc_r, in_ch.rx_byte);
  assign rx_crc  = {in_ch.rx_byte, crc_lo_r};

  assign good_ext = EXT_W'(good_cnt_nxt);
  assign err_ext  = EXT_W'(err_cnt_nxt);
  assign chg_ext  = EXT_W'(chg_cnt_nxt);

  always_comb begin
    pos_nxt      = pos_r;
    crc_nxt      = crc_r;
    hdr_ok_nxt   = hdr_ok_r;
    cnt_ok_nxt   = cnt_ok_r;
    dist_hi_nxt  = dist_hi_r;
    dist_lo_nxt  = dist_lo_r;
    crc_lo_nxt   = crc_lo_r;
    prev_hi_nxt  = prev_hi_r;
    has_prev_nxt = has_prev_r;
    good_cnt_nxt = good_cnt_r;
    err_cnt_nxt  = err_cnt_r;
    chg_cnt_nxt  = chg_cnt_r;
    status_nxt   = ST_OK;
    changed_nxt  = 1'b0;
    out_valid_nxt = out_hold;

    if (in_fire && (pos_eff != POS_IDLE)) begin
      pos_nxt = pos_eff + 3'd1;
      case (pos_eff)
        POS_ADDR: begin
          crc_nxt    = crc_upd;
          hdr_ok_nxt = (in_ch.rx_byte == exp_addr_r);
          cnt_ok_nxt = 1'b0;
        end
        POS_FUNC: begin
          crc_nxt    = crc_upd;
          hdr_ok_nxt = hdr_ok_r && (in_ch.rx_byte == exp_func_r);
        end
        POS_COUNT: begin
          crc_nxt    = crc_upd;
          cnt_ok_nxt = (in_ch.rx_byte == BYTE_COUNT);
        end
        POS_DHIGH: begin
          crc_nxt     = crc_upd;
          dist_hi_nxt = in_ch.rx_byte;
        end
        POS_DLOW: begin
          crc_nxt     = crc_upd;
          dist_lo_nxt = in_ch.rx_byte;
        end
        POS_CRCLO: begin
          crc_lo_nxt = in_ch.rx_byte;
        end
        POS_CRCHI: begin
          pos_nxt       = POS_IDLE;
          out_valid_nxt = 1'b1;
          if (!hdr_ok_r) begin
            status_nxt = ST_BAD_HDR;
          end else if (!cnt_ok_r) begin
            status_nxt = ST_BAD_COUNT;
          end else begin
            if (crc_r == rx_crc) begin
              status_nxt = ST_OK;
              if (good_cnt_r != '1) good_cnt_nxt = good_cnt_r + 1'b1;
            end else begin
              status_nxt = ST_CRC_ERR;
              if (err_cnt_r != '1) err_cnt_nxt = err_cnt_r + 1'b1;
            end
            if (has_prev_r && (dist_hi_r != prev_hi_r)) begin
              changed_nxt = 1'b1;
              if (chg_cnt_r != '1) chg_cnt_nxt = chg_cnt_r + 1'b1;
            end
            prev_hi_nxt  = dist_hi_r;
            has_prev_nxt = 1'b1;
          end
        end
        default: begin
          pos_nxt = POS_IDLE;
        end
      endcase
    end
  end

  assign dist_out_nxt = {dist_hi_r, dist_lo_r};
  assign ccrc_out_nxt = crc_r;
  assign rcrc_out_nxt = rx_crc;
  assign good_out_nxt = good_ext[OUT_COUNT_W-1:0];
  assign err_out_nxt  = err_ext[OUT_COUNT_W-1:0];
  assign chg_out_nxt  = chg_ext[OUT_COUNT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_addr_r  <= ADDR_RESET;
      exp_func_r  <= FUNC_RESET;
      pos_r       <= POS_IDLE;
      crc_r       <= CRC_INIT;
      hdr_ok_r    <= 1'b0;
      cnt_ok_r    <= 1'b0;
      has_prev_r  <= 1'b0;
      good_cnt_r  <= '0;
      err_cnt_r   <= '0;
      chg_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.reg_index)
          REG_EXP_ADDR: exp_addr_r <= cfg_ch.wdata;
          REG_EXP_FUNC: exp_func_r <= cfg_ch.wdata;
          default: ;
        endcase
      end
      pos_r       <= pos_nxt;
      crc_r       <= crc_nxt;
      hdr_ok_r    <= hdr_ok_nxt;
      cnt_ok_r    <= cnt_ok_nxt;
      has_prev_r  <= has_prev_nxt;
      good_cnt_r  <= good_cnt_nxt;
      err_cnt_r   <= err_cnt_nxt;
      chg_cnt_r   <= chg_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    dist_hi_r <= dist_hi_nxt;
    dist_lo_r <= dist_lo_nxt;
    crc_lo_r  <= crc_lo_nxt;
    prev_hi_r <= prev_hi_nxt;
    if (!out_hold) begin
      status_r   <= status_nxt;
      dist_out_r <= dist_out_nxt;
      ccrc_out_r <= ccrc_out_nxt;
      rcrc_out_r <= rcrc_out_nxt;
      changed_r  <= changed_nxt;
      good_out_r <= good_out_nxt;
      err_out_r  <= err_out_nxt;
      chg_out_r  <= chg_out_nxt;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.status            = status_r;
  assign out_ch.distance_mm       = dist_out_r;
  assign out_ch.computed_crc      = ccrc_out_r;
  assign out_ch.received_crc      = rcrc_out_r;
  assign out_ch.high_byte_changed = changed_r;
  assign out_ch.good_frames       = good_out_r;
  assign out_ch.crc_failures      = err_out_r;
  assign out_ch.high_changes      = chg_out_r;

endmodule

@@ hdl/mrc_checker.sv @@
// port-level assertions for modbus_response_checker_core, with its bind
// depends on mrc_pkg and modbus_response_checker_core_assert.svh
`include "modbus_response_checker_core_assert.svh"

module mrc_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input mrc_pkg::status_t               status,
  input logic [15:0]                    distance_mm,
  input logic                           high_byte_changed,
  input logic [mrc_pkg::OUT_COUNT_W-1:0] good_frames
);
  import mrc_pkg::*;

  // a held result keeps its payload
  `MRC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(status) && $stable(distance_mm) && $stable(good_frames))

  // a result leaves only when taken
  `MRC_ASSERT_NOW(a_out_leave, clk, rst_n, $fell(out_valid), $past(out_ready) || !$past(rst_n))

  // input backpressure only while a result is stuck
  `MRC_ASSERT_NOW(a_in_stall, clk, rst_n, !in_ready, out_valid && !out_ready)

  // rejected frames never flag a high byte change
  `MRC_ASSERT_NOW(a_bad_no_change, clk, rst_n, out_valid && (status == ST_BAD_HDR || status == ST_BAD_COUNT), !high_byte_changed)

endmodule

bind modbus_response_checker_core mrc_checker u_mrc_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .status            (out_ch.status),
  .distance_mm       (out_ch.distance_mm),
  .high_byte_changed (out_ch.high_byte_changed),
  .good_frames       (out_ch.good_frames)
);
